### rtl/amdfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amdfs_pkg: shared types and constants for the adjacency matrix DFS block
// Operation codes, the controller state type and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package amdfs_pkg;

  localparam int VW = 5;   // vertex field width
  localparam int FW = 2;   // operation field width
  localparam int CW = 6;   // vertex count register width

  localparam int MAX_VERTICES_DEFAULT = 32;
  localparam logic [CW-1:0] VERTEX_COUNT_RESET = 6'd32;

  localparam logic [FW-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FW-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FW-1:0] FUNC_SEARCH = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_REPORT,
    S_QUERY,
    S_ADD_A,
    S_ADD_B,
    S_SCAN,
    S_POP,
    S_FINISH
  } state_t;

  // Source of the adjacency row read address
  typedef enum logic [2:0] {
    ADJ_RD_NONE,
    ADJ_RD_A,
    ADJ_RD_B,
    ADJ_RD_NEXT,
    ADJ_RD_STACK
  } adj_rd_t;

  // Read-modify-write of one adjacency row
  typedef enum logic [1:0] {
    ADJ_WR_NONE,
    ADJ_WR_A,
    ADJ_WR_B
  } adj_wr_t;

  // Which result is loaded into the output register
  typedef enum logic [2:0] {
    EMIT_ERROR,
    EMIT_ACK,
    EMIT_QUERY,
    EMIT_STEP,
    EMIT_FINAL
  } emit_t;

  typedef struct packed {
    logic    load;      // latch the incoming operation
    adj_rd_t adj_rd;
    adj_wr_t adj_wr;
    logic    start;     // mark, push and hold the start vertex
    logic    advance;   // mark, push and hold the lowest unvisited neighbour
    logic    pop;       // drop the stack top and fetch the one below
    logic    emit;
    emit_t   emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic           bad;        // unused code or vertex out of range
    logic [FW-1:0]  func;
    logic           cand_any;   // top of stack has an unvisited neighbour
    logic           sp_last;    // one entry left on the stack
    logic           slot_free;  // output register can take a result
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/adjacency_matrix_dfs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs: undirected graph store with depth-first search
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// The block holds an undirected graph of up to MAX_VERTICES vertices as a
// symmetric bit matrix in a memory with one read port and one write port
// (one row read and one row written per cycle, registered read data), plus
// a register of visited marks and a search stack. Each input transaction
// carries one operation: add edge returns one acknowledgement, query edge
// returns the stored edge bit, and search returns every newly reached vertex
// in depth-first order (lowest-numbered neighbour first), with last set on
// the final one. Visited marks persist from search to search until reset; a
// search from a visited vertex still reports that vertex. A vertex at or
// beyond the active count (vertex_count clipped to MAX_VERTICES), or an
// unused operation code, gives a single result with error and last set and
// changes nothing. Reset clears the matrix at once through per-row valid
// bits, so there is no clearing pass. One operation is in flight at a time,
// but a finished result waits in the output register while the next
// transaction is taken. Add edge makes two read-modify-write row updates,
// one per row, with the second row read while the first is written. A
// search starts by marking and pushing the start vertex; each backtrack
// step is a stack read, then a row read, and the last step is the pop and
// the final result. The stack and row reads are registered, and output
// stalls can hold every operation. Write vertex_count only while the block
// is idle.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs import amdfs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // input channel
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [FW-1:0] func,
  input  wire logic [VW-1:0] vertex_a,
  input  wire logic [VW-1:0] vertex_b,
  // result channel
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [FW-1:0]      kind,
  output logic [VW-1:0]      vertex,
  output logic               connected,
  output logic               error,
  output logic               last,
  // vertex_count register
  input  wire logic          cfg_we,
  input  wire logic [CW-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: accepts a transaction, then steps the datapath through it
  amdfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: matrix, marks, stack and the output register
  amdfs_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .vertex_a  (vertex_a),
    .vertex_b  (vertex_b),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .kind      (kind),
    .vertex    (vertex),
    .connected (connected),
    .error     (error),
    .last      (last)
  );

endmodule
`default_nettype wire

### rtl/amdfs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amdfs_dp: datapath of the adjacency matrix DFS block
// Adjacency memory with row valid bits, visited marks, search stack,
// neighbour selection and the output register.
// ----------------------------------------------------------------------------
module amdfs_dp import amdfs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [FW-1:0] func,
  input  wire logic [VW-1:0] vertex_a,
  input  wire logic [VW-1:0] vertex_b,
  input  wire logic          cfg_we,
  input  wire logic [CW-1:0] cfg_wdata,
  input  wire dp_cmd_t       cmd,
  output dp_stat_t           stat,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [FW-1:0]      kind,
  output logic [VW-1:0]      vertex,
  output logic               connected,
  output logic               error,
  output logic               last
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  typedef logic [MAX_VERTICES-1:0] row_t;

  logic [CW-1:0] vertex_count;
  logic [FW-1:0] func_q;
  logic [VW-1:0] a_q;
  logic [VW-1:0] b_q;

  row_t          adj_mem [MAX_VERTICES];
  row_t          row_ok;
  row_t          row_q;
  logic          row_valid_q;
  row_t          visited;

  logic [AW-1:0] stk_mem [MAX_VERTICES];
  logic [AW-1:0] stk_q;
  logic [NW-1:0] sp;
  logic [AW-1:0] pend;

  logic [NW-1:0] n;
  row_t          mask;
  logic [AW-1:0] a_idx;
  logic [AW-1:0] b_idx;
  row_t          row_eff;
  row_t          cand;
  logic [AW-1:0] next_idx;
  logic          adj_re;
  logic [AW-1:0] adj_ra;
  logic          adj_we;
  logic [AW-1:0] adj_wa;
  row_t          adj_wd;
  logic          push;
  logic [AW-1:0] push_addr;
  logic [AW-1:0] push_data;
  logic          func_bad;

  function automatic logic [AW-1:0] lowest(row_t v);
    logic [AW-1:0] idx;
    idx = '0;
    for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
      if (v[j]) idx = AW'(j);
    end
    return idx;
  endfunction

  // Active count: register clipped to the matrix size
  always_comb begin
    if (int'(vertex_count) > MAX_VERTICES) n = NW'(MAX_VERTICES);
    else n = NW'(vertex_count);
    for (int j = 0; j < MAX_VERTICES; j++) begin
      mask[j] = (j < int'(n));
    end
  end

  assign a_idx    = AW'(a_q);
  assign b_idx    = AW'(b_q);
  assign row_eff  = row_valid_q ? row_q : '0;
  assign cand     = row_eff & mask & ~visited;
  assign next_idx = lowest(cand);

  assign func_bad = !(func_q == FUNC_ADD || func_q == FUNC_QUERY || func_q == FUNC_SEARCH);

  always_comb begin
    stat.bad       = func_bad || (int'(a_q) >= int'(n))
                     || (func_q != FUNC_SEARCH && int'(b_q) >= int'(n));
    stat.func      = func_q;
    stat.cand_any  = |cand;
    stat.sp_last   = (sp == NW'(1));
    stat.slot_free = !out_valid || !out_stall;
  end

  // Adjacency port selection
  always_comb begin
    adj_re = 1'b1;
    unique case (cmd.adj_rd)
      ADJ_RD_NONE:  begin adj_re = 1'b0; adj_ra = a_idx; end
      ADJ_RD_A:     adj_ra = a_idx;
      ADJ_RD_B:     adj_ra = b_idx;
      ADJ_RD_NEXT:  adj_ra = next_idx;
      ADJ_RD_STACK: adj_ra = stk_q;
      default:      begin adj_re = 1'b0; adj_ra = a_idx; end
    endcase
    adj_we = 1'b1;
    unique case (cmd.adj_wr)
      ADJ_WR_NONE: begin adj_we = 1'b0; adj_wa = a_idx; adj_wd = row_eff; end
      ADJ_WR_A:    begin adj_wa = a_idx; adj_wd = row_eff | (row_t'(1) << b_idx); end
      ADJ_WR_B:    begin adj_wa = b_idx; adj_wd = row_eff | (row_t'(1) << a_idx); end
      default:     begin adj_we = 1'b0; adj_wa = a_idx; adj_wd = row_eff; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    if (adj_re) row_q <= adj_mem[adj_ra];
  end

  // Search stack
  assign push      = cmd.start || cmd.advance;
  assign push_addr = cmd.start ? '0 : AW'(sp);
  assign push_data = cmd.start ? a_idx : next_idx;

  always_ff @(posedge clk) begin
    if (push) stk_mem[push_addr] <= push_data;
    if (cmd.pop) stk_q <= stk_mem[AW'(sp - NW'(2))];
  end

  // Control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
      row_ok       <= '0;
      row_valid_q  <= 1'b0;
      visited      <= '0;
      sp           <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) vertex_count <= cfg_wdata;
      if (adj_we) row_ok[adj_wa] <= 1'b1;
      if (adj_re) row_valid_q <= row_ok[adj_ra];
      if (cmd.start) begin
        visited[a_idx] <= 1'b1;
        sp             <= NW'(1);
      end else if (cmd.advance) begin
        visited[next_idx] <= 1'b1;
        sp                <= sp + NW'(1);
      end else if (cmd.pop) begin
        sp <= sp - NW'(1);
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Operation latch, pending vertex and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      a_q    <= vertex_a;
      b_q    <= vertex_b;
    end
    if (cmd.start) pend <= a_idx;
    else if (cmd.advance) pend <= next_idx;
    if (cmd.emit) begin
      kind      <= func_q;
      vertex    <= '0;
      connected <= 1'b0;
      error     <= 1'b0;
      last      <= 1'b1;
      unique case (cmd.emit_sel)
        EMIT_ERROR: error <= 1'b1;
        EMIT_ACK:   ;
        EMIT_QUERY: connected <= row_eff[b_idx];
        EMIT_STEP:  begin vertex <= VW'(pend); last <= 1'b0; end
        EMIT_FINAL: vertex <= VW'(pend);
        default:    error <= 1'b1;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/amdfs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amdfs_ctrl: controller of the adjacency matrix DFS block
// Sequences edge updates, queries and the stack-driven search.
// ----------------------------------------------------------------------------
module amdfs_ctrl import amdfs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    cmd.load     = 1'b0;
    cmd.adj_rd   = ADJ_RD_NONE;
    cmd.adj_wr   = ADJ_WR_NONE;
    cmd.start    = 1'b0;
    cmd.advance  = 1'b0;
    cmd.pop      = 1'b0;
    cmd.emit     = 1'b0;
    cmd.emit_sel = EMIT_ERROR;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (stat.bad) begin
          state_next = S_REPORT;
        end else if (stat.func == FUNC_ADD) begin
          cmd.adj_rd = ADJ_RD_A;
          state_next = S_ADD_A;
        end else if (stat.func == FUNC_QUERY) begin
          cmd.adj_rd = ADJ_RD_A;
          state_next = S_QUERY;
        end else begin
          cmd.start  = 1'b1;
          cmd.adj_rd = ADJ_RD_A;
          state_next = S_SCAN;
        end
      end
      S_REPORT: begin
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_ERROR;
          state_next   = S_IDLE;
        end
      end
      S_QUERY: begin
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_QUERY;
          state_next   = S_IDLE;
        end
      end
      S_ADD_A: begin
        cmd.adj_wr = ADJ_WR_A;
        cmd.adj_rd = ADJ_RD_B;
        state_next = S_ADD_B;
      end
      S_ADD_B: begin
        // the OR write is idempotent, so repeat it while the output is full
        cmd.adj_wr = ADJ_WR_B;
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_ACK;
          state_next   = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.cand_any) begin
          if (stat.slot_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EMIT_STEP;
            cmd.advance  = 1'b1;
            cmd.adj_rd   = ADJ_RD_NEXT;
          end
        end else begin
          cmd.pop = 1'b1;
          if (stat.sp_last) state_next = S_FINISH;
          else state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.adj_rd = ADJ_RD_STACK;
        state_next = S_SCAN;
      end
      S_FINISH: begin
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_FINAL;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/amdfs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amdfs_checker: port-level checks for the adjacency matrix DFS block
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module amdfs_checker import amdfs_pkg::*; (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire logic [FW-1:0] kind,
  input wire logic [VW-1:0] vertex,
  input wire logic          connected,
  input wire logic          error,
  input wire logic          last
);

  // Hold a stalled result unchanged
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(vertex)
      && $stable(connected) && $stable(error) && $stable(last))
    else $error("stalled result changed");

  // An error result closes its transaction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && !connected && vertex == '0)
    else $error("error result not final or not clean");

  // Only search results can carry a vertex or have last clear
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != FUNC_SEARCH |-> vertex == '0 && last)
    else $error("non-search result carries a vertex or is not final");

  // The edge bit appears only on a valid query
  assert property (@(posedge clk) disable iff (rst)
    out_valid && connected |-> kind == FUNC_QUERY && !error)
    else $error("connected set outside a query");

endmodule

bind adjacency_matrix_dfs amdfs_checker u_amdfs_checker (.*);
`default_nettype wire
